/* design/swm_pkg.sv */
// Shared constants, types and register codes of the square window mean filter.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int WINDOW   = 10;
	localparam int MAX_ROWS = 128;
	localparam int MAX_COLS = 1024;

	localparam int PIX_W   = 8;
	localparam int PIX_MAX = (1 << PIX_W) - 1;
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int SLOT_W  = $clog2(WINDOW);

	localparam int ROWS_CFG_W = 8;
	localparam int COLS_CFG_W = 11;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'(64);
	localparam logic [COLS_CFG_W-1:0] COLS_RST = COLS_CFG_W'(512);

	// running sum widths
	localparam int RSUM_W   = $clog2(WINDOW * PIX_MAX + 1);
	localparam int WIN_AREA = WINDOW * WINDOW;
	localparam int WSUM_W   = $clog2(WIN_AREA * PIX_MAX + 1);

	// pixel history: WINDOW column slots by MAX_ROWS rows
	localparam int HIST_DEPTH = WINDOW * MAX_ROWS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// divide by WIN_AREA as multiply by rounded-up reciprocal, exact for WSUM_W-bit sums
	localparam int DIV_L   = $clog2(WIN_AREA);
	localparam int DIV_S   = WSUM_W + DIV_L;
	localparam int DIV_M_W = WSUM_W + 1;
	localparam int PROD_W  = WSUM_W + DIV_M_W;
	localparam logic [DIV_M_W-1:0] DIV_M =
		DIV_M_W'(((longint'(1) << DIV_S) + longint'(WIN_AREA) - 1) / longint'(WIN_AREA));

	// configuration port
	localparam int APB_DW    = 32;
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = 1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_ROWS = 1'b0,
		REG_FRAME_COLS = 1'b1
	} swm_reg_t;

	// effective frame geometry, already clamped
	typedef struct packed {
		logic [ROWS_CFG_W-1:0] rows;
		logic [COLS_CFG_W-1:0] cols;
	} swm_geom_t;

endpackage

/* design/swm_pix_if.sv */
// Pixel input channel: valid/ready handshake with pixel and frame start.
`timescale 1ns / 1ps

interface swm_pix_if import swm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

/* design/swm_win_if.sv */
// Window result channel: valid/ready handshake with mean, position and last flag.
`timescale 1ns / 1ps

interface swm_win_if import swm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] mean;
	logic [ROW_W-1:0] win_row;
	logic [COL_W-1:0] win_col;
	logic             last_window;

	modport source (output valid, output mean, output win_row, output win_col,
		output last_window, input ready);
	modport sink   (input valid, input mean, input win_row, input win_col,
		input last_window, output ready);
endinterface

/* design/swm_regs.sv */
// Configuration registers behind the APB-style port, with geometry clamping.
`timescale 1ns / 1ps

module swm_regs import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	output swm_geom_t          geom
);

	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;
	swm_reg_t              reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = swm_reg_t'(paddr[PADDR_W-1 -: REG_IDX_W]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_ROWS: rows_q <= pwdata[ROWS_CFG_W-1:0];
				REG_FRAME_COLS: cols_q <= pwdata[COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_ROWS: prdata = APB_DW'(rows_q);
			REG_FRAME_COLS: prdata = APB_DW'(cols_q);
			default:        prdata = '0;
		endcase
	end

	// clamp to 1..MAX
	always_comb begin
		if (rows_q == '0)
			geom.rows = ROWS_CFG_W'(1);
		else if (rows_q > ROWS_CFG_W'(MAX_ROWS))
			geom.rows = ROWS_CFG_W'(MAX_ROWS);
		else
			geom.rows = rows_q;

		if (cols_q == '0)
			geom.cols = COLS_CFG_W'(1);
		else if (cols_q > COLS_CFG_W'(MAX_COLS))
			geom.cols = COLS_CFG_W'(MAX_COLS);
		else
			geom.cols = cols_q;
	end

endmodule

/* design/square_window_mean.sv */
// Top level of the streaming WINDOW x WINDOW box-filter mean over a column-major frame.
// A result is registered in stage 1, stage 2 and the stage 3 output register after its pixel is accepted.
// Throughput: one pixel per cycle unless a stalled result holds the input; the row-sum and pixel-history
// memories are read once at input acceptance and written back from stage 1, with forwarding between them.
// Reset clears position counters, the vertical running sum, its taps and all valids;
// geometry returns to 64 rows by 512 columns. The memories are not cleared.
`timescale 1ns / 1ps

module square_window_mean import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	swm_pix_if.sink            pix,
	swm_win_if.source          win
);

	swm_geom_t geom;

	swm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.geom    (geom)
	);

	// position of the next pixel
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] tap_q;

	logic [ROW_W-1:0]   r_in;
	logic [COL_W-1:0]   c_in;
	logic [SLOT_W-1:0]  slot_in;
	logic [SLOT_W-1:0]  tap_in;
	logic [SLOT_W-1:0]  slot_nx;
	logic [SLOT_W-1:0]  tap_nx;
	logic [HIST_AW-1:0] haddr_in;
	logic               row_wrap;
	logic               col_wrap;
	logic               pix_fire;

	// stage 1
	logic               v_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [ROW_W-1:0]   r_s1;
	logic [COL_W-1:0]   c_s1;
	logic [SLOT_W-1:0]  tap_s1;
	logic [HIST_AW-1:0] haddr_s1;
	logic               col0_s1;
	logic               colw_s1;
	logic               row0_s1;
	logic               rowge_s1;
	logic               res_s1;
	logic               last_s1;
	logic [RSUM_W-1:0]  rsum_rd_s1;
	logic [PIX_W-1:0]   hist_rd_s1;

	logic [RSUM_W-1:0] rs_new;
	logic [RSUM_W-1:0] old_tap;
	logic [WSUM_W-1:0] ws_new;
	logic [WSUM_W-1:0] ws_q;
	logic [RSUM_W-1:0] taps_q [WINDOW];

	// stage 2
	logic              v_s2;
	logic [WSUM_W-1:0] ws_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;
	logic              last_s2;
	logic [PROD_W-1:0] prod;

	// stage 3 (output register)
	logic             v_s3;
	logic [PIX_W-1:0] mean_s3;
	logic [ROW_W-1:0] row_s3;
	logic [COL_W-1:0] col_s3;
	logic             last_s3;

	logic adv_s1;
	logic adv_s2;
	logic rdy_s2;
	logic rdy_s3;

	logic [RSUM_W-1:0] rsum_mem [MAX_ROWS];
	logic [PIX_W-1:0]  hist_mem [HIST_DEPTH];

	// pipeline flow; items without a result leave stage 1 without taking stage 2
	assign rdy_s3    = !v_s3 || win.ready;
	assign adv_s2    = v_s2 && rdy_s3;
	assign rdy_s2    = !v_s2 || adv_s2;
	assign adv_s1    = v_s1 && (!res_s1 || rdy_s2);
	assign pix.ready = !v_s1 || adv_s1;
	assign pix_fire  = pix.valid && pix.ready;

	assign r_in    = pix.frame_start ? '0 : row_q;
	assign c_in    = pix.frame_start ? '0 : col_q;
	assign slot_in = pix.frame_start ? '0 : slot_q;
	assign tap_in  = pix.frame_start ? '0 : tap_q;

	assign slot_nx  = (slot_in == SLOT_W'(WINDOW - 1)) ? '0 : slot_in + SLOT_W'(1);
	assign tap_nx   = (tap_in == SLOT_W'(WINDOW - 1)) ? '0 : tap_in + SLOT_W'(1);
	assign row_wrap = (ROWS_CFG_W'(r_in) + ROWS_CFG_W'(1)) >= geom.rows;
	assign col_wrap = (COLS_CFG_W'(c_in) + COLS_CFG_W'(1)) >= geom.cols;
	assign haddr_in = HIST_AW'({slot_in, r_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
			tap_q  <= '0;
		end else if (pix_fire) begin
			if (row_wrap) begin
				row_q <= '0;
				tap_q <= '0;
				if (col_wrap) begin
					col_q  <= '0;
					slot_q <= '0;
				end else begin
					col_q  <= c_in + COL_W'(1);
					slot_q <= slot_nx;
				end
			end else begin
				row_q  <= r_in + ROW_W'(1);
				tap_q  <= tap_nx;
				col_q  <= c_in;
				slot_q <= slot_in;
			end
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			pix_s1   <= pix.pixel;
			r_s1     <= r_in;
			c_s1     <= c_in;
			tap_s1   <= tap_in;
			haddr_s1 <= haddr_in;
			col0_s1  <= (c_in == '0);
			colw_s1  <= (c_in < COL_W'(WINDOW));
			row0_s1  <= (r_in == '0);
			rowge_s1 <= (r_in >= ROW_W'(WINDOW));
			res_s1   <= (r_in >= ROW_W'(WINDOW - 1)) && (c_in >= COL_W'(WINDOW - 1));
			last_s1  <= (ROWS_CFG_W'(r_in) == geom.rows - ROWS_CFG_W'(1)) &&
				(COLS_CFG_W'(c_in) == geom.cols - COLS_CFG_W'(1));
		end
	end

	// memories: write-back from stage 1, registered read at acceptance
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsum_mem[r_s1]     <= rs_new;
			hist_mem[haddr_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			// same-edge write from stage 1 is forwarded
			if (adv_s1 && (r_s1 == r_in))
				rsum_rd_s1 <= rs_new;
			else
				rsum_rd_s1 <= rsum_mem[r_in];
			if (adv_s1 && (haddr_s1 == haddr_in))
				hist_rd_s1 <= pix_s1;
			else
				hist_rd_s1 <= hist_mem[haddr_in];
		end
	end

	always_comb begin
		if (col0_s1)
			rs_new = RSUM_W'(pix_s1);
		else if (colw_s1)
			rs_new = rsum_rd_s1 + RSUM_W'(pix_s1);
		else
			rs_new = rsum_rd_s1 + RSUM_W'(pix_s1) - RSUM_W'(hist_rd_s1);

		old_tap = rowge_s1 ? taps_q[tap_s1] : '0;

		if (row0_s1)
			ws_new = WSUM_W'(rs_new);
		else
			ws_new = ws_q + WSUM_W'(rs_new) - WSUM_W'(old_tap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ws_q <= '0;
			for (int i = 0; i < WINDOW; i++)
				taps_q[i] <= '0;
		end else begin
			if (pix_fire)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;

			if (adv_s1) begin
				ws_q           <= ws_new;
				taps_q[tap_s1] <= rs_new;
			end

			if (adv_s1 && res_s1)
				v_s2 <= 1'b1;
			else if (adv_s2)
				v_s2 <= 1'b0;

			if (adv_s2)
				v_s3 <= 1'b1;
			else if (win.ready)
				v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_s1) begin
			ws_s2   <= ws_new;
			row_s2  <= r_s1 - ROW_W'(WINDOW - 1);
			col_s2  <= c_s1 - COL_W'(WINDOW - 1);
			last_s2 <= last_s1;
		end
	end

	assign prod = PROD_W'(ws_s2) * PROD_W'(DIV_M);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mean_s3 <= prod[DIV_S +: PIX_W];
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
		end
	end

	assign win.valid       = v_s3;
	assign win.mean        = mean_s3;
	assign win.win_row     = row_s3;
	assign win.win_col     = col_s3;
	assign win.last_window = last_s3;

endmodule

/* design/swm_checker.sv */
// Port-level checks of the square window mean filter, bound to the top level.
`timescale 1ns / 1ps

module swm_checker import swm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	swm_pix_if.sink   pix,
	swm_win_if.source win
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		win.valid && !win.ready |=> win.valid && $stable(win.mean) &&
			$stable(win.win_row) && $stable(win.win_col) && $stable(win.last_window))
		else $error("result changed while stalled");

	// input backpressure only comes from a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> win.valid && !win.ready)
		else $error("pixel input stalled without output backpressure");

	// window position stays inside the largest frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		win.valid |-> (win.win_row <= ROW_W'(MAX_ROWS - WINDOW)) &&
			(win.win_col <= COL_W'(MAX_COLS - WINDOW)))
		else $error("window position out of range");

	// no result and a ready config port while in reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !win.valid && pready)
		else $error("output valid during reset");

endmodule

bind square_window_mean swm_checker u_swm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pready (pready),
	.pix    (pix),
	.win    (win)
);

/* tb/swm_mean_checker.sv */
// Checker for the square window mean filter: tracks geometry writes, predicts window results.
`timescale 1ns / 1ps

module swm_mean_checker import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               pready,
	swm_pix_if                 pix,
	swm_win_if                 win,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic [ROW_W-1:0] win_row;
		logic [COL_W-1:0] win_col;
		logic             last_window;
	} win_result_t;

	logic [ROWS_CFG_W-1:0] rows_cfg;
	logic [COLS_CFG_W-1:0] cols_cfg;
	logic [ROW_W-1:0]      row_pos;
	logic [COL_W-1:0]      col_pos;
	logic [PIX_W-1:0]      history [WINDOW][MAX_ROWS];
	logic [RSUM_W-1:0]     row_sum [MAX_ROWS];
	logic [RSUM_W-1:0]     col_taps [WINDOW];
	logic [WSUM_W-1:0]     box_sum;
	win_result_t           expected_wins [$];

	function automatic int clamp_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// One pixel through the filter; queues the window it completes, if any.
	task automatic filter_pixel(input logic [PIX_W-1:0] p, input logic fs);
		int rows, cols, r, c, slot, tap;
		int unsigned rs, old_rs;
		win_result_t res;
		rows = clamp_dim(int'(rows_cfg), MAX_ROWS);
		cols = clamp_dim(int'(cols_cfg), MAX_COLS);
		if (fs) begin
			row_pos = '0;
			col_pos = '0;
		end
		r = int'(row_pos);
		c = int'(col_pos);
		slot = c % WINDOW;

		// horizontal sum over the last WINDOW columns of this row
		if (c == 0)
			rs = p;
		else if (c < WINDOW)
			rs = row_sum[r] + p;
		else
			rs = row_sum[r] + p - history[slot][r];
		row_sum[r] = RSUM_W'(rs);
		history[slot][r] = p;

		// vertical sum over the last WINDOW row sums of this column
		tap = r % WINDOW;
		old_rs = (r >= WINDOW) ? col_taps[tap] : 0;
		if (r == 0)
			box_sum = WSUM_W'(rs);
		else
			box_sum = WSUM_W'(box_sum + rs - old_rs);
		col_taps[tap] = RSUM_W'(rs);

		if (r >= WINDOW - 1 && c >= WINDOW - 1) begin
			res.mean        = PIX_W'(box_sum / WIN_AREA);
			res.win_row     = ROW_W'(r - (WINDOW - 1));
			res.win_col     = COL_W'(c - (WINDOW - 1));
			res.last_window = (r == rows - 1) && (c == cols - 1);
			expected_wins.insert(expected_wins.size(), res);
		end

		if (r + 1 >= rows) begin
			row_pos = '0;
			col_pos = (c + 1 >= cols) ? '0 : COL_W'(c + 1);
		end else begin
			row_pos = ROW_W'(r + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		win_result_t exp_win, got_win;
		if (!arst_n) begin
			rows_cfg = ROWS_RST;
			cols_cfg = COLS_RST;
			row_pos  = '0;
			col_pos  = '0;
			box_sum  = '0;
			foreach (col_taps[i]) col_taps[i] = '0;
			foreach (row_sum[i]) row_sum[i] = '0;
			foreach (history[i, j]) history[i][j] = '0;
			expected_wins.delete();
			errors = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (swm_reg_t'(paddr[2 +: REG_IDX_W]))
					REG_FRAME_ROWS: rows_cfg = pwdata[ROWS_CFG_W-1:0];
					REG_FRAME_COLS: cols_cfg = pwdata[COLS_CFG_W-1:0];
					default: ;
				endcase
			end
			if (win.valid && win.ready) begin
				got_win = {win.mean, win.win_row, win.win_col, win.last_window};
				if (expected_wins.size() == 0) begin
					errors++;
					$display("%0t: unexpected window: mean %0d row %0d col %0d last %0d",
						$time, got_win.mean, got_win.win_row, got_win.win_col,
						got_win.last_window);
				end else begin
					exp_win = expected_wins.pop_front();
					if (got_win.mean !== exp_win.mean || got_win.win_row !== exp_win.win_row ||
						got_win.win_col !== exp_win.win_col ||
						got_win.last_window !== exp_win.last_window) begin
						errors++;
						// fields in order mean/row/col/last
						$display("%0t: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
							$time, exp_win.mean, exp_win.win_row, exp_win.win_col,
							exp_win.last_window, got_win.mean, got_win.win_row,
							got_win.win_col, got_win.last_window);
					end
				end
			end
			if (pix.valid && pix.ready)
				filter_pixel(pix.pixel, pix.frame_start);
		end
		pending = expected_wins.size();
	end

endmodule

/* tb/square_window_mean_tb.sv */
// Testbench top for the square window mean filter: frames, geometry writes, stalls, verdict.
`timescale 1ns / 1ps

module square_window_mean_tb import swm_pkg::*; ();

	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SETTLE       = 8;    // cycles past the pipeline
	localparam int LONG_FRAME   = 600;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	int                 chk_errors;
	int                 chk_pending;
	int                 cycles;
	logic               tx_burst = 1'b0;
	logic               rx_burst = 1'b0;
	int                 rows_set;
	int                 cols_set;
	bit                 aligned;    // position known to be at the top of column 0

	swm_pix_if pix_ch ();
	swm_win_if win_ch ();

	square_window_mean dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_ch),
		.win     (win_ch)
	);

	swm_mean_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.pix     (pix_ch),
		.win     (win_ch),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("square_window_mean_tb NOT OK");
		$finish;
	end

	// result side: a fresh random stall, possibly none, before every transaction
	initial begin
		int stall;
		win_ch.ready = 1'b0;
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (stall != 0) begin
				win_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			win_ch.ready <= 1'b1;
			@(posedge clk);
			while (!win_ch.valid) @(posedge clk);
		end
	end

	function automatic int eff_dim(int v, int hi);
		return (v < 1) ? 1 : (v > hi) ? hi : v;
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value, input logic fs);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			pix_ch.valid       <= 1'b0;
			pix_ch.pixel       <= PIX_W'($urandom());
			pix_ch.frame_start <= 1'($urandom());
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel       <= value;
		pix_ch.frame_start <= fs;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
	endtask

	// random pixels; a stray frame start now and then when noisy
	task automatic send_run(input int count, input logic fs_first, input bit noisy);
		logic fs;
		for (int i = 0; i < count; i++) begin
			fs = (i == 0) ? fs_first : 1'b0;
			if (noisy && i != 0 && $urandom_range(0, 399) == 0) begin
				fs = 1'b1;
				aligned = 1'b0;
			end
			send_pixel(PIX_W'($urandom()), fs);
		end
	endtask

	// holds the stream until every window is out and the pipeline is empty
	task automatic drain();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (chk_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input swm_reg_t idx, input int value);
		logic [APB_DW-1:0] data;
		data = $urandom();
		case (idx)
			REG_FRAME_ROWS: data[ROWS_CFG_W-1:0] = ROWS_CFG_W'(value);
			REG_FRAME_COLS: data[COLS_CFG_W-1:0] = COLS_CFG_W'(value);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(int'(idx) * 4);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_geometry(input int rows, input int cols);
		drain();
		write_reg(REG_FRAME_ROWS, rows);
		write_reg(REG_FRAME_COLS, cols);
		rows_set = rows;
		cols_set = cols;
	endtask

	initial begin
		int   rows, cols, frame_px, count, cut, kind, random_items;
		bit   broken;
		logic fs_first;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel       = '0;
		pix_ch.frame_start = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// zero geometry clamps to one pixel per frame: no windows
		set_geometry(0, 0);
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h55, 1'b1);
		send_pixel(8'hAA, 1'b0);

		// single-window frames: full white, then black following without frame start
		set_geometry(WINDOW, WINDOW);
		for (int i = 0; i < WINDOW * WINDOW; i++)
			send_pixel(8'hFF, i == 0);
		for (int i = 0; i < WINDOW * WINDOW; i++)
			send_pixel(8'h00, 1'b0);

		// rows code above the limit, one full column of two; the next frame starts
		// in column 1 only if the rows wrapped at the clamped height
		set_geometry(255, 2);
		send_run(MAX_ROWS, 1'b0, 1'b0);
		set_geometry(WINDOW + 2, WINDOW + 1);
		send_run((WINDOW + 2) * (WINDOW + 1), 1'b0, 1'b0);
		aligned = 1'b0;

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			kind     = $urandom_range(0, 15);
			tx_burst = ($urandom_range(0, 4) == 0);
			rx_burst = ($urandom_range(0, 4) == 0);
			if (kind < 11) begin
				rows = $urandom_range(WINDOW, WINDOW + 6);
				cols = $urandom_range(WINDOW, WINDOW + 3);
			end else if (kind == 11) begin
				rows = $urandom_range(0, WINDOW - 1);
				cols = $urandom_range(0, WINDOW + 3);
			end else if (kind == 12) begin
				rows = $urandom_range(WINDOW, WINDOW + 6);
				cols = $urandom_range(0, WINDOW - 1);
			end else if (kind == 13) begin
				rows = $urandom_range(WINDOW + 7, 255);
				cols = $urandom_range(WINDOW, WINDOW + 1);
			end else if (kind == 14) begin
				rows = $urandom_range(WINDOW, WINDOW + 2);
				cols = $urandom_range(WINDOW + 4, 2047);
			end else begin
				rows = $urandom_range(0, 255);
				cols = $urandom_range(0, 2047);
			end
			set_geometry(rows, cols);

			frame_px = eff_dim(rows, MAX_ROWS) * eff_dim(cols, MAX_COLS);
			if (frame_px > LONG_FRAME) begin
				// long frames are cut short
				count  = $urandom_range(50, 400);
				broken = 1'b1;
			end else begin
				count  = frame_px * $urandom_range(1, 3);
				broken = ($urandom_range(0, 4) == 0);
				if (broken)
					count = $urandom_range(1, count);
			end

			// off the frame grid the first pixel has to restart the frame
			fs_first = aligned ? 1'($urandom()) : 1'b1;
			aligned  = 1'b1;
			if (!broken && count > 1 && $urandom_range(0, 5) == 0) begin
				// shrink rows mid-frame, any cols; the frame is meaningless afterwards
				cut = $urandom_range(1, count - 1);
				send_run(cut, fs_first, 1'b1);
				set_geometry($urandom_range(0, eff_dim(rows_set, MAX_ROWS)),
					$urandom_range(0, 2047));
				send_run(count - cut, 1'b0, 1'b1);
				broken = 1'b1;
			end else begin
				send_run(count, fs_first, 1'b1);
			end
			if (broken)
				aligned = 1'b0;
			random_items += count;
		end

		tx_burst = 1'b0;
		rx_burst = 1'b0;
		drain();
		if (chk_errors == 0 && chk_pending == 0)
			$display("square_window_mean_tb OK");
		else
			$display("square_window_mean_tb NOT OK");
		$finish;
	end

endmodule
